// ----- src/btgr_pkg.sv -----
`default_nettype none

package btgr_pkg;

  // Coordinate width default and fixed field widths
  localparam int COORD_WIDTH_DEF = 16;
  localparam int GLYPH_ROWS      = 7;
  localparam int GLYPH_COLS      = 5;
  localparam int GLYPH_BITS      = GLYPH_ROWS * GLYPH_COLS;
  localparam int OFF_WIDTH       = 7;   // holds 6 * 15

  // Character codes
  localparam logic [7:0] FIRST_CODE    = 8'd32;
  localparam logic [7:0] LAST_CODE     = 8'd122;
  localparam logic [7:0] FALLBACK_CODE = 8'd63;
  localparam logic [7:0] NEWLINE_CODE  = 8'd10;

  // Register indexes
  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_SCALE    = 2'd2;
  localparam logic [1:0] REG_COLOR    = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Control from sequencer to the scan unit
  typedef struct packed {
    logic                  load;
    logic [GLYPH_BITS-1:0] glyph;
    logic [3:0]            scale;
  } scan_ctl_t;

  // Glyph bits, row 0 first, column 0 is the MSB of each 5-bit row
  function automatic logic [GLYPH_BITS-1:0] glyph_rom(input logic [6:0] idx);
    logic [GLYPH_BITS-1:0] g;
    unique case (idx)
      7'd0:  g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      7'd1:  g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
      7'd2:  g = {5'h0A, 5'h0A, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      7'd3:  g = {5'h0A, 5'h1F, 5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h00};
      7'd4:  g = {5'h04, 5'h0F, 5'h14, 5'h0E, 5'h05, 5'h1E, 5'h04};
      7'd5:  g = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
      7'd6:  g = {5'h08, 5'h14, 5'h14, 5'h08, 5'h15, 5'h12, 5'h0D};
      7'd7:  g = {5'h04, 5'h04, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      7'd8:  g = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
      7'd9:  g = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
      7'd10: g = {5'h00, 5'h04, 5'h15, 5'h0E, 5'h15, 5'h04, 5'h00};
      7'd11: g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
      7'd12: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08};
      7'd13: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      7'd14: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
      7'd15: g = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
      7'd16: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      7'd17: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'd18: g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
      7'd19: g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
      7'd20: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      7'd21: g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      7'd22: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      7'd23: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      7'd24: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      7'd25: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      7'd26: g = {5'h00, 5'h00, 5'h04, 5'h00, 5'h04, 5'h00, 5'h00};
      7'd27: g = {5'h00, 5'h00, 5'h04, 5'h00, 5'h04, 5'h04, 5'h08};
      7'd28: g = {5'h02, 5'h04, 5'h08, 5'h10, 5'h08, 5'h04, 5'h02};
      7'd29: g = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00};
      7'd30: g = {5'h08, 5'h04, 5'h02, 5'h01, 5'h02, 5'h04, 5'h08};
      7'd31: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
      7'd32: g = {5'h0E, 5'h11, 5'h17, 5'h15, 5'h17, 5'h10, 5'h0E};
      7'd33: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      7'd34: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      7'd35: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      7'd36: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      7'd37: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      7'd38: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      7'd39: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      7'd40: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      7'd41: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'd42: g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
      7'd43: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      7'd44: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      7'd45: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      7'd46: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      7'd47: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      7'd48: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      7'd49: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      7'd50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      7'd51: g = {5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E};
      7'd52: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      7'd53: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      7'd54: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
      7'd55: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
      7'd56: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      7'd57: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      7'd58: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      7'd59: g = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
      7'd60: g = {5'h10, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h01};
      7'd61: g = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
      7'd62: g = {5'h04, 5'h0A, 5'h11, 5'h00, 5'h00, 5'h00, 5'h00};
      7'd63: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
      7'd64: g = {5'h08, 5'h04, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      7'd65: g = {5'h00, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F};
      7'd66: g = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
      7'd67: g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h10, 5'h11, 5'h0E};
      7'd68: g = {5'h01, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h11, 5'h0F};
      7'd69: g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E};
      7'd70: g = {5'h06, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h08, 5'h08};
      7'd71: g = {5'h00, 5'h00, 5'h0F, 5'h11, 5'h0F, 5'h01, 5'h0E};
      7'd72: g = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11};
      7'd73: g = {5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'd74: g = {5'h02, 5'h00, 5'h06, 5'h02, 5'h02, 5'h12, 5'h0C};
      7'd75: g = {5'h10, 5'h10, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12};
      7'd76: g = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'd77: g = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h15, 5'h15};
      7'd78: g = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11};
      7'd79: g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
      7'd80: g = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
      7'd81: g = {5'h00, 5'h00, 5'h0F, 5'h11, 5'h0F, 5'h01, 5'h01};
      7'd82: g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
      7'd83: g = {5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E};
      7'd84: g = {5'h08, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h09, 5'h06};
      7'd85: g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0F};
      7'd86: g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      7'd87: g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A};
      7'd88: g = {5'h00, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
      7'd89: g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E};
      7'd90: g = {5'h00, 5'h00, 5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
      default: g = '0;
    endcase
    return g;
  endfunction

  // Map a character byte to its glyph; unknown codes show the fallback glyph
  function automatic logic [GLYPH_BITS-1:0] glyph_of(input logic [7:0] code);
    logic [7:0] c;
    logic [7:0] idx;
    c   = (code < FIRST_CODE || code > LAST_CODE) ? FALLBACK_CODE : code;
    idx = c - FIRST_CODE;
    return glyph_rom(idx[6:0]);
  endfunction

endpackage

`default_nettype wire

// ----- src/btgr_in_if.sv -----
`default_nettype none

interface btgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_of_text;

  modport source (output valid, char_code, start_of_text, input ready);
  modport sink   (input valid, char_code, start_of_text, output ready);
endinterface

`default_nettype wire

// ----- src/btgr_out_if.sv -----
`default_nettype none

interface btgr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic [3:0]         rect_size;
  logic [31:0]        rect_color;
  logic               last_of_char;

  modport source (output valid, rect_x, rect_y, rect_size, rect_color, last_of_char,
                  input ready);
  modport sink   (input valid, rect_x, rect_y, rect_size, rect_color, last_of_char,
                  output ready);
endinterface

`default_nettype wire

// ----- src/btgr_scan.sv -----
`default_nettype none

// Glyph scanner: one bit per cycle, a square per lit bit; busy output stalls it
module btgr_scan
  import btgr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire scan_ctl_t              ctl,
  input  wire logic [COORD_WIDTH-1:0] pen_x,
  input  wire logic [COORD_WIDTH-1:0] pen_y,
  input  wire logic [31:0]            color,
  output      logic                   empty,
  btgr_out_if.source                  out_ch
);

  logic [GLYPH_BITS-1:0] sh_r, sh_nxt;
  logic [2:0]            col_r, col_nxt;
  logic [OFF_WIDTH-1:0]  col_off_r, col_off_nxt;
  logic [OFF_WIDTH-1:0]  row_off_r, row_off_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [15:0]    rect_x_r, rect_y_r;
  logic [3:0]            rect_size_r;
  logic [31:0]           rect_color_r;
  logic                  last_r;

  logic                   free;
  logic                   step;
  logic                   emit;
  logic [COORD_WIDTH-1:0] sum_x, sum_y;
  logic [OFF_WIDTH-1:0]   scale_ext;

  assign scale_ext = OFF_WIDTH'(ctl.scale);
  assign empty     = (sh_r == '0);
  assign free      = !out_valid_r || out_ch.ready;
  assign step      = !empty && (!sh_r[GLYPH_BITS-1] || free);
  assign emit      = step && sh_r[GLYPH_BITS-1];

  // Square corner for the bit at the head of the shift register
  assign sum_x = pen_x + COORD_WIDTH'(col_off_r);
  assign sum_y = pen_y + COORD_WIDTH'(row_off_r);

  // Scan position and offsets
  always_comb begin
    sh_nxt      = sh_r;
    col_nxt     = col_r;
    col_off_nxt = col_off_r;
    row_off_nxt = row_off_r;
    if (ctl.load) begin
      sh_nxt      = ctl.glyph;
      col_nxt     = '0;
      col_off_nxt = '0;
      row_off_nxt = '0;
    end else if (step) begin
      sh_nxt = {sh_r[GLYPH_BITS-2:0], 1'b0};
      if (col_r == 3'(GLYPH_COLS - 1)) begin
        col_nxt     = '0;
        col_off_nxt = '0;
        row_off_nxt = row_off_r + scale_ext;
      end else begin
        col_nxt     = col_r + 3'd1;
        col_off_nxt = col_off_r + scale_ext;
      end
    end
  end

  // Output register handshake
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r        <= '0;
      col_r       <= '0;
      col_off_r   <= '0;
      row_off_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sh_r        <= sh_nxt;
      col_r       <= col_nxt;
      col_off_r   <= col_off_nxt;
      row_off_r   <= row_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, loaded on each emitted square
  always_ff @(posedge clk) begin
    if (emit) begin
      rect_x_r     <= 16'(sum_x);
      rect_y_r     <= 16'(sum_y);
      rect_size_r  <= ctl.scale;
      rect_color_r <= color;
      last_r       <= (sh_r[GLYPH_BITS-2:0] == '0);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.rect_x       = rect_x_r;
  assign out_ch.rect_y       = rect_y_r;
  assign out_ch.rect_size    = rect_size_r;
  assign out_ch.rect_color   = rect_color_r;
  assign out_ch.last_of_char = last_r;

  // A new glyph is only loaded once the previous scan has drained
  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> empty)
    else $error("glyph loaded while scan still active");

  // A pending square that is not the last one leaves lit bits to scan
  a_more_after_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !last_r |-> !empty)
    else $error("non-final square pending with nothing left to scan");

  // Column counter never leaves the glyph width
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < 3'(GLYPH_COLS))
    else $error("column counter out of range");

endmodule

`default_nettype wire

// ----- src/bitmap_text_glyph_rasterizer.sv -----
// Order: once a character is accepted its glyph is loaded into the scan shift register; when
//   glyph row 0, column 0 is lit the first square is registered once the output is free.
// A character passes through accept, bit scans ending at the last lit bit, and pen advance;
//   a blank glyph skips the bit scans, a newline only moves the pen. A new character is not
//   accepted before the pen advance. One square per cycle at most.
// Reset (rst_n, synchronous, active low): pen at 0,0, origin 0,0, scale 1, color 0,
//   no square pending.
`default_nettype none

module bitmap_text_glyph_rasterizer
  import btgr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  btgr_in_if.sink          in_ch,
  btgr_out_if.source       out_ch
);

  logic [15:0] origin_x_r;
  logic [15:0] origin_y_r;
  logic [3:0]  scale_r;
  logic [31:0] color_r;

  state_t                 state_r, state_nxt;
  logic [COORD_WIDTH-1:0] pen_x_r, pen_x_nxt;
  logic [COORD_WIDTH-1:0] pen_y_r, pen_y_nxt;

  logic                   wr_en;
  logic [1:0]             reg_idx;
  logic [3:0]             scale;
  logic [OFF_WIDTH-1:0]   char_step;
  logic [OFF_WIDTH-1:0]   line_step;
  logic [COORD_WIDTH-1:0] org_x, org_y;
  logic [COORD_WIDTH-1:0] base_y;
  logic                   accept;
  logic                   scan_empty;
  scan_ctl_t              scan_ctl;

  // Register port
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      scale_r    <= 4'd1;
      color_r    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ORIGIN_X: origin_x_r <= pwdata[15:0];
        REG_ORIGIN_Y: origin_y_r <= pwdata[15:0];
        REG_SCALE:    scale_r    <= pwdata[3:0];
        REG_COLOR:    color_r    <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X: prdata = 32'(origin_x_r);
      REG_ORIGIN_Y: prdata = 32'(origin_y_r);
      REG_SCALE:    prdata = 32'(scale_r);
      REG_COLOR:    prdata = color_r;
      default:      prdata = '0;
    endcase
  end

  // Scale in use and pen steps (6s and 8s)
  assign scale     = (scale_r == '0) ? 4'd1 : scale_r;
  assign char_step = (OFF_WIDTH'(scale) << 2) + (OFF_WIDTH'(scale) << 1);
  assign line_step = OFF_WIDTH'(scale) << 3;

  // Origin sign-extended (or wrapped) to the pen width
  assign org_x = COORD_WIDTH'($signed(origin_x_r));
  assign org_y = COORD_WIDTH'($signed(origin_y_r));

  assign accept = in_ch.valid && in_ch.ready;
  assign base_y = in_ch.start_of_text ? org_y : pen_y_r;

  // Sequencer: pen update and scan start
  always_comb begin
    state_nxt      = state_r;
    pen_x_nxt      = pen_x_r;
    pen_y_nxt      = pen_y_r;
    in_ch.ready    = (state_r == ST_IDLE);
    scan_ctl.load  = 1'b0;
    scan_ctl.glyph = glyph_of(in_ch.char_code);
    scan_ctl.scale = scale;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.char_code == NEWLINE_CODE) begin
            pen_x_nxt = org_x;
            pen_y_nxt = base_y + COORD_WIDTH'(line_step);
          end else begin
            if (in_ch.start_of_text) begin
              pen_x_nxt = org_x;
              pen_y_nxt = org_y;
            end
            scan_ctl.load = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_empty) begin
          pen_x_nxt = pen_x_r + COORD_WIDTH'(char_step);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      state_r <= state_nxt;
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

  btgr_scan #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (scan_ctl),
    .pen_x  (pen_x_r),
    .pen_y  (pen_y_r),
    .color  (color_r),
    .empty  (scan_empty),
    .out_ch (out_ch)
  );

  // Every accepted character other than newline starts a scan
  a_char_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.char_code != NEWLINE_CODE |=> state_r == ST_SCAN)
    else $error("character accepted without starting a scan");

  // Newline returns the pen to the origin column
  a_newline_col: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.char_code == NEWLINE_CODE |=> pen_x_r == $past(org_x))
    else $error("newline did not return pen to origin column");

  // While idle the scanner has nothing left to walk
  a_idle_scan_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> scan_empty)
    else $error("sequencer idle while scan still active");

endmodule

`default_nettype wire
